// ===== rtl/core/spimbx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spimbx_pkg: shared types and constants of the spi byte exchange master
// Configuration record, response record, register indexes and the sck
// divisor table.
// ----------------------------------------------------------------------------
package spimbx_pkg;

   // default build values
   localparam int DATA_BITS_DEFAULT   = 8;
   localparam int MAX_DIVISOR_DEFAULT = 128;

   // field widths fixed by the interface
   localparam int BYTE_W     = 8;
   localparam int RATE_W     = 3;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;
   localparam int DIVISOR_W  = 8;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RATE_SELECT = 2'd0,
      CSR_SPI_MODE    = 2'd1,
      CSR_LSB_FIRST   = 2'd2,
      CSR_ENABLE      = 2'd3
   } csr_index_type;

   // configuration registers as seen by the engine
   typedef struct packed {
      logic [RATE_W-1:0] rate_select;
      logic [MODE_W-1:0] spi_mode;
      logic              lsb_first;
      logic              enable;
   } cfg_type;

   // one response item
   typedef struct packed {
      logic              sck_out;
      logic              mosi_out;
      logic              busy_res;
      logic              done_res;
      logic [BYTE_W-1:0] received_byte;
      logic              write_collision;
   } rsp_type;

   // sck divisor from {double, r1, r0}
   function automatic logic [DIVISOR_W-1:0] divisor_of(input logic [RATE_W-1:0] code);
      logic [DIVISOR_W-1:0] div;
      case (code)
         3'd0:    div = 8'd4;
         3'd1:    div = 8'd16;
         3'd2:    div = 8'd64;
         3'd3:    div = 8'd128;
         3'd4:    div = 8'd2;
         3'd5:    div = 8'd8;
         3'd6:    div = 8'd32;
         3'd7:    div = 8'd64;
         default: div = 8'd4;
      endcase
      return div;
   endfunction

endpackage

// ===== rtl/core/spimbx_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spimbx_csr: configuration registers
// Holds rate select, spi mode, bit order and enable; written by index.
// ----------------------------------------------------------------------------
module spimbx_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [spimbx_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [spimbx_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output spimbx_pkg::cfg_type                 cfg
);

   spimbx_pkg::cfg_type cfg_ff;
   spimbx_pkg::cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (spimbx_pkg::csr_index_type'(csr_index))
            spimbx_pkg::CSR_RATE_SELECT: cfg_in.rate_select = csr_write_data[2:0];
            spimbx_pkg::CSR_SPI_MODE:    cfg_in.spi_mode    = csr_write_data[1:0];
            spimbx_pkg::CSR_LSB_FIRST:   cfg_in.lsb_first   = csr_write_data[0];
            spimbx_pkg::CSR_ENABLE:      cfg_in.enable      = csr_write_data[0];
            default:                     cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/spimbx_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spimbx_engine: spi transfer state and per-tick update
// Shift register, prescaler, edge counter and sck/mosi levels; one tick of
// the serial engine per accepted request.
// ----------------------------------------------------------------------------
module spimbx_engine #(
   parameter int DATA_BITS   = spimbx_pkg::DATA_BITS_DEFAULT,
   parameter int MAX_DIVISOR = spimbx_pkg::MAX_DIVISOR_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  spimbx_pkg::cfg_type              cfg,
   input  logic                             step,
   input  logic                             operation,
   input  logic [spimbx_pkg::BYTE_W-1:0]    send_byte,
   input  logic                             miso_in,
   output spimbx_pkg::rsp_type              result
);

   localparam int EDGE_W     = $clog2(2 * DATA_BITS + 1);
   localparam int PRESCALE_W = $clog2(MAX_DIVISOR / 2 + 1);
   localparam int WIDE_W     = (DATA_BITS > spimbx_pkg::BYTE_W) ? DATA_BITS
                                                                : spimbx_pkg::BYTE_W;
   localparam logic [EDGE_W-1:0] TOTAL_EDGES = EDGE_W'(2 * DATA_BITS);
   localparam logic [spimbx_pkg::DIVISOR_W-1:0] DIV_LIMIT =
      spimbx_pkg::DIVISOR_W'(MAX_DIVISOR);

   logic [DATA_BITS-1:0]  shift_ff,    shift_in;
   logic [EDGE_W-1:0]     edge_ff,     edge_in;
   logic [PRESCALE_W-1:0] prescale_ff, prescale_in;
   logic                  sck_ff,      sck_in;
   logic                  active_ff,   active_in;
   logic [DATA_BITS-1:0]  hold_ff,     hold_in;
   logic                  mosi_ff,     mosi_in;

   logic [spimbx_pkg::DIVISOR_W-1:0] divisor;
   logic [spimbx_pkg::DIVISOR_W-1:0] divisor_clamped;
   logic [PRESCALE_W-1:0]            half_period;
   logic [WIDE_W-1:0]                send_wide;
   logic [WIDE_W-1:0]                hold_wide;
   logic                             done;
   logic                             collision;

   // half period of sck in ticks, at least one
   always_comb begin
      divisor         = spimbx_pkg::divisor_of(cfg.rate_select);
      divisor_clamped = (divisor > DIV_LIMIT) ? DIV_LIMIT : divisor;
      half_period     = PRESCALE_W'(divisor_clamped >> 1);
      if (half_period == '0) begin
         half_period = PRESCALE_W'(1);
      end
   end

   assign send_wide = WIDE_W'(send_byte);

   // one tick of the serial engine
   always_comb begin
      logic cpol;
      logic cpha;
      logic leading;
      cpol        = cfg.spi_mode[1];
      cpha        = cfg.spi_mode[0];
      leading     = 1'b0;
      shift_in    = shift_ff;
      edge_in     = edge_ff;
      prescale_in = prescale_ff;
      sck_in      = sck_ff;
      active_in   = active_ff;
      hold_in     = hold_ff;
      mosi_in     = mosi_ff;
      done        = 1'b0;
      collision   = 1'b0;
      if (!cfg.enable) begin
         active_in   = 1'b0;
         edge_in     = '0;
         prescale_in = '0;
         sck_in      = cpol;
      end else if (active_ff) begin
         collision   = operation;
         prescale_in = prescale_ff + PRESCALE_W'(1);
         if (prescale_in >= half_period) begin
            leading     = ~edge_ff[0];
            prescale_in = '0;
            sck_in      = ~sck_ff;
            edge_in     = edge_ff + EDGE_W'(1);
            if (leading != cpha) begin
               // sample miso into the shift register
               if (cfg.lsb_first) begin
                  shift_in = {miso_in, shift_ff[DATA_BITS-1:1]};
               end else begin
                  shift_in = {shift_ff[DATA_BITS-2:0], miso_in};
               end
            end else if (edge_in < TOTAL_EDGES) begin
               mosi_in = cfg.lsb_first ? shift_ff[0] : shift_ff[DATA_BITS-1];
            end
            // last edge: latch the received word
            if (edge_in >= TOTAL_EDGES) begin
               done      = 1'b1;
               hold_in   = shift_in;
               active_in = 1'b0;
               edge_in   = '0;
               sck_in    = cpol;
            end
         end
      end else begin
         sck_in = cpol;
         if (operation) begin
            shift_in    = send_wide[DATA_BITS-1:0];
            active_in   = 1'b1;
            edge_in     = '0;
            prescale_in = '0;
            if (!cpha) begin
               mosi_in = cfg.lsb_first ? shift_in[0] : shift_in[DATA_BITS-1];
            end
         end
      end
   end

   // state update on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff    <= '0;
         edge_ff     <= '0;
         prescale_ff <= '0;
         sck_ff      <= 1'b0;
         active_ff   <= 1'b0;
         hold_ff     <= '0;
         mosi_ff     <= 1'b0;
      end else if (step) begin
         shift_ff    <= shift_in;
         edge_ff     <= edge_in;
         prescale_ff <= prescale_in;
         sck_ff      <= sck_in;
         active_ff   <= active_in;
         hold_ff     <= hold_in;
         mosi_ff     <= mosi_in;
      end
   end

   // response fields from the updated state
   assign hold_wide = WIDE_W'(hold_in);

   always_comb begin
      result.sck_out         = sck_in;
      result.mosi_out        = mosi_in;
      result.busy_res        = active_in;
      result.done_res        = done;
      result.received_byte   = hold_wide[spimbx_pkg::BYTE_W-1:0];
      result.write_collision = collision;
   end

endmodule

// ===== rtl/core/spi_master_byte_exchange_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_master_byte_exchange_top: spi master, one byte exchange per transfer
//
//   port group | direction | handshake         | payload
//   req_*      | in        | req_valid/ready   | operation, send_byte, miso_in
//   rsp_*      | out       | rsp_valid/ready   | sck, mosi, busy, done, rx, coll
//   csr_*      | in        | csr_write_enable  | csr_index, csr_write_data
//
// One request per cycle unless stalled; its response appears in the output
// register on the next cycle. The whole tick update is one pass of logic after
// the state registers, so the request rate is set by the response register alone.
// A request is taken whenever the response register is empty or being read.
// Synchronous reset clears configuration, transfer state and response valid.
// ----------------------------------------------------------------------------
module spi_master_byte_exchange_top #(
   parameter int DATA_BITS   = spimbx_pkg::DATA_BITS_DEFAULT,
   parameter int MAX_DIVISOR = spimbx_pkg::MAX_DIVISOR_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic [spimbx_pkg::BYTE_W-1:0]       req_send_byte,
   input  logic                                req_miso_in,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_sck_out,
   output logic                                rsp_mosi_out,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic [spimbx_pkg::BYTE_W-1:0]       rsp_received_byte,
   output logic                                rsp_write_collision,
   // configuration write port
   input  logic                                csr_write_enable,
   input  logic [spimbx_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [spimbx_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   spimbx_pkg::cfg_type cfg;
   spimbx_pkg::rsp_type result;
   spimbx_pkg::rsp_type rsp_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                step;

   spimbx_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   spimbx_engine #(
      .DATA_BITS   (DATA_BITS),
      .MAX_DIVISOR (MAX_DIVISOR)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (step),
      .operation (req_operation),
      .send_byte (req_send_byte),
      .miso_in   (req_miso_in),
      .result    (result)
   );

   // request handshake
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign step      = req_valid & req_ready;

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sck_out         = rsp_ff.sck_out;
   assign rsp_mosi_out        = rsp_ff.mosi_out;
   assign rsp_busy_res        = rsp_ff.busy_res;
   assign rsp_done_res        = rsp_ff.done_res;
   assign rsp_received_byte   = rsp_ff.received_byte;
   assign rsp_write_collision = rsp_ff.write_collision;

endmodule

// ===== rtl/core/spimbx_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spimbx_checker: port-level checks of the spi byte exchange master
// Watches the request and response handshakes and response flag relations.
// ----------------------------------------------------------------------------
module spimbx_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_busy_res,
   input logic                             rsp_done_res,
   input logic                             rsp_write_collision,
   input logic [spimbx_pkg::BYTE_W-1:0]    rsp_received_byte
);

   // no response right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // request side stalls only behind a stalled response
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a stalled response");

   // a finished transfer is no longer busy
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> !rsp_busy_res)
      else $error("done while still busy");

   // a collision only happens during a transfer
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_write_collision) |-> (rsp_busy_res || rsp_done_res))
      else $error("collision outside a transfer");

   // a stalled response holds its data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_received_byte)))
      else $error("stalled response changed");

endmodule

bind spi_master_byte_exchange_top spimbx_checker u_spimbx_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_busy_res        (rsp_busy_res),
   .rsp_done_res        (rsp_done_res),
   .rsp_write_collision (rsp_write_collision),
   .rsp_received_byte   (rsp_received_byte)
);

// ===== tb/tb_spi_master_byte_exchange_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spi_master_byte_exchange_top: self-checking bench for the spi byte master
// Every accepted request is one system tick. A local predictor of the sck
// prescaler, edge counter and shift register works out the response of each
// tick, which is compared field by field with what the block returns. A short
// directed table covers the reset state and the special cases. Random phases
// with new register settings then run transfers under bursty requests and a
// stalling response side.
// ----------------------------------------------------------------------------
module tb_spi_master_byte_exchange_top;
   import spimbx_pkg::*;

   // request operation codes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // rate codes {double, r1, r0}
   localparam logic [RATE_W-1:0] RATE_DIV4      = 3'd0;
   localparam logic [RATE_W-1:0] RATE_DIV16     = 3'd1;
   localparam logic [RATE_W-1:0] RATE_DIV64     = 3'd2;
   localparam logic [RATE_W-1:0] RATE_DIV128    = 3'd3;
   localparam logic [RATE_W-1:0] RATE_DIV2      = 3'd4;
   localparam logic [RATE_W-1:0] RATE_DIV8      = 3'd5;
   localparam logic [RATE_W-1:0] RATE_DIV32     = 3'd6;
   localparam logic [RATE_W-1:0] RATE_DIV64_DBL = 3'd7;

   // spi modes {cpol, cpha}
   localparam logic [MODE_W-1:0] MODE_0 = 2'd0;
   localparam logic [MODE_W-1:0] MODE_1 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_2 = 2'd2;
   localparam logic [MODE_W-1:0] MODE_3 = 2'd3;

   localparam logic [4:0] EDGES_PER_BYTE = 5'd16;
   localparam int RANDOM_ITEMS   = 680;
   localparam int QUIET_LIMIT    = 2000;
   localparam int LONG_HOLD      = 300;

   // directed table rows
   typedef enum logic [1:0] {
      ROW_TICK,
      ROW_RUN,
      ROW_REG
   } row_kind_type;

   typedef struct {
      row_kind_type          kind;
      csr_index_type         reg_index;
      logic [CSR_DATA_W-1:0] reg_value;
      logic                  op;
      logic [BYTE_W-1:0]     send;
      logic                  miso;
      int                    count;
      bit                    typed;
      rsp_type               typed_rsp;
   } stim_row_type;

   // predictor state of the serial engine
   typedef struct packed {
      logic [BYTE_W-1:0] shreg;
      logic [4:0]        edges;
      logic [6:0]        prescale;
      logic              sck;
      logic              active;
      logic [BYTE_W-1:0] rx_hold;
      logic              mosi;
   } spi_state_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_operation = OP_TICK;
   logic [BYTE_W-1:0]     req_send_byte = '0;
   logic                  req_miso_in = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_sck_out;
   logic                  rsp_mosi_out;
   logic                  rsp_busy_res;
   logic                  rsp_done_res;
   logic [BYTE_W-1:0]     rsp_received_byte;
   logic                  rsp_write_collision;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   logic                  hold_arm = 1'b0;
   spi_state_type         spi_st = '0;
   cfg_type               spi_cfg = '0;
   rsp_type               expected_rsp[$];
   stim_row_type          stim_table[$];
   int                    failures = 0;
   int                    quiet_cycles = 0;

   spi_master_byte_exchange_top uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_send_byte       (req_send_byte),
      .req_miso_in         (req_miso_in),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sck_out         (rsp_sck_out),
      .rsp_mosi_out        (rsp_mosi_out),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_done_res        (rsp_done_res),
      .rsp_received_byte   (rsp_received_byte),
      .rsp_write_collision (rsp_write_collision),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   // 10 ns system clock
   always #5 clock = ~clock;

   // ticks per sck half period
   function automatic logic [6:0] half_ticks(input logic [RATE_W-1:0] code);
      logic [6:0] half;
      case (code)
         RATE_DIV4:   half = 7'd2;
         RATE_DIV16:  half = 7'd8;
         RATE_DIV64:  half = 7'd32;
         RATE_DIV128: half = 7'd64;
         RATE_DIV2:   half = 7'd1;
         RATE_DIV8:   half = 7'd4;
         RATE_DIV32:  half = 7'd16;
         default:     half = 7'd32;
      endcase
      return half;
   endfunction

   // one system tick of the predicted engine
   function automatic rsp_type spi_tick(input logic op, input logic [BYTE_W-1:0] send,
                                        input logic miso);
      rsp_type r;
      logic    cpol;
      logic    cpha;
      logic    leading;
      logic    collided;
      logic    finished;
      cpol     = spi_cfg.spi_mode[1];
      cpha     = spi_cfg.spi_mode[0];
      collided = 1'b0;
      finished = 1'b0;
      if (!spi_cfg.enable) begin
         // port off: drop any transfer, park sck, mosi keeps its level
         spi_st.active   = 1'b0;
         spi_st.edges    = '0;
         spi_st.prescale = '0;
         spi_st.sck      = cpol;
      end else if (spi_st.active) begin
         if (op == OP_START) collided = 1'b1;
         spi_st.prescale = spi_st.prescale + 7'd1;
         if (spi_st.prescale >= half_ticks(spi_cfg.rate_select)) begin
            leading         = ~spi_st.edges[0];
            spi_st.prescale = '0;
            spi_st.sck      = ~spi_st.sck;
            spi_st.edges    = spi_st.edges + 5'd1;
            if (leading != cpha) begin
               spi_st.shreg = spi_cfg.lsb_first ? {miso, spi_st.shreg[BYTE_W-1:1]}
                                                : {spi_st.shreg[BYTE_W-2:0], miso};
            end else if (spi_st.edges < EDGES_PER_BYTE) begin
               spi_st.mosi = spi_cfg.lsb_first ? spi_st.shreg[0] : spi_st.shreg[BYTE_W-1];
            end
            // last edge: latch the byte and park sck
            if (spi_st.edges >= EDGES_PER_BYTE) begin
               finished       = 1'b1;
               spi_st.rx_hold = spi_st.shreg;
               spi_st.active  = 1'b0;
               spi_st.edges   = '0;
               spi_st.sck     = cpol;
            end
         end
      end else begin
         spi_st.sck = cpol;
         if (op == OP_START) begin
            spi_st.shreg    = send;
            spi_st.active   = 1'b1;
            spi_st.edges    = '0;
            spi_st.prescale = '0;
            if (!cpha)
               spi_st.mosi = spi_cfg.lsb_first ? send[0] : send[BYTE_W-1];
         end
      end
      r.sck_out         = spi_st.sck;
      r.mosi_out        = spi_st.mosi;
      r.busy_res        = spi_st.active;
      r.done_res        = finished;
      r.received_byte   = spi_st.rx_hold;
      r.write_collision = collided;
      return r;
   endfunction

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endfunction

   function automatic string rsp_text(input rsp_type r);
      return $sformatf("sck=%0b mosi=%0b busy=%0b done=%0b rx=%02h coll=%0b", r.sck_out,
                       r.mosi_out, r.busy_res, r.done_res, r.received_byte,
                       r.write_collision);
   endfunction

   // table builders
   function automatic void push_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      stim_row_type row;
      row           = '{kind: ROW_REG, reg_index: CSR_RATE_SELECT, default: '0};
      row.reg_index = idx;
      row.reg_value = val;
      stim_table.push_back(row);
   endfunction

   function automatic void push_tick(input logic op, input logic [BYTE_W-1:0] send,
                                     input logic miso);
      stim_row_type row;
      row      = '{kind: ROW_TICK, reg_index: CSR_RATE_SELECT, default: '0};
      row.op   = op;
      row.send = send;
      row.miso = miso;
      stim_table.push_back(row);
   endfunction

   function automatic void push_typed(input logic op, input logic [BYTE_W-1:0] send,
                                      input logic miso, input rsp_type want);
      push_tick(op, send, miso);
      stim_table[$].typed     = 1'b1;
      stim_table[$].typed_rsp = want;
   endfunction

   function automatic void push_run(input int count);
      stim_row_type row;
      row       = '{kind: ROW_RUN, reg_index: CSR_RATE_SELECT, default: '0};
      row.count = count;
      stim_table.push_back(row);
   endfunction

   // offer one request and hold it until accepted, then log its response
   task automatic offer(input logic op, input logic [BYTE_W-1:0] send, input logic miso,
                        input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_send_byte    <= send;
      req_miso_in      <= miso;
      csr_write_enable <= 1'b0;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = spi_tick(op, send, miso);
      expected_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   // register write once every response is back
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      case (idx)
         CSR_RATE_SELECT: spi_cfg.rate_select = val[RATE_W-1:0];
         CSR_SPI_MODE:    spi_cfg.spi_mode    = val[MODE_W-1:0];
         CSR_LSB_FIRST:   spi_cfg.lsb_first   = val[0];
         default:         spi_cfg.enable      = val[0];
      endcase
   endtask

   // response side: stall pattern in stretches, one long hold when armed
   initial begin
      int stall_mode;
      int stretch;
      int beat;
      bit hold_taken;
      hold_taken = 1'b0;
      beat       = 0;
      forever begin
         stall_mode = $urandom_range(0, 3);
         stretch    = $urandom_range(5, 60);
         repeat (stretch) begin
            @(posedge clock);
            beat++;
            if (hold_arm && !hold_taken) begin
               hold_taken = 1'b1;
               rsp_ready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
            end else begin
               case (stall_mode)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= ($urandom_range(0, 3) != 0);
                  2:       rsp_ready <= (beat % 3 == 0);
                  default: rsp_ready <= $urandom_range(0, 1);
               endcase
            end
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      string   diffs;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.sck_out         = rsp_sck_out;
         seen.mosi_out        = rsp_mosi_out;
         seen.busy_res        = rsp_busy_res;
         seen.done_res        = rsp_done_res;
         seen.received_byte   = rsp_received_byte;
         seen.write_collision = rsp_write_collision;
         if (expected_rsp.size() == 0) begin
            note_failure($sformatf("response with no request outstanding: %s",
                                   rsp_text(seen)));
         end else begin
            want  = expected_rsp.pop_front();
            diffs = "";
            if (seen.sck_out !== want.sck_out) diffs = {diffs, " sck_out"};
            if (seen.mosi_out !== want.mosi_out) diffs = {diffs, " mosi_out"};
            if (seen.busy_res !== want.busy_res) diffs = {diffs, " busy_res"};
            if (seen.done_res !== want.done_res) diffs = {diffs, " done_res"};
            if (seen.received_byte !== want.received_byte) diffs = {diffs, " received_byte"};
            if (seen.write_collision !== want.write_collision)
               diffs = {diffs, " write_collision"};
            if (diffs != "")
               note_failure($sformatf("mismatch in%s: expected %s, got %s", diffs,
                                      rsp_text(want), rsp_text(seen)));
         end
      end
   end

   // watchdog on cycles without any handshake or register write
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("spi_master_byte_exchange_top test failed");
         $finish;
      end
   end

   // stimulus
   initial begin
      rsp_type           parked;
      rsp_type           none;
      stim_row_type      row;
      logic [RATE_W-1:0] rate;
      logic [MODE_W-1:0] mode;
      logic              lsb;
      logic              en;
      logic              op;
      logic [BYTE_W-1:0] send;
      int                items_left;
      int                phase;
      int                phase_items;
      int                burst_left;
      int                gap;
      int                sel;
      int                waited;

      none          = '0;
      parked        = '0;
      parked.sck_out = 1'b1;

      // reset state and disabled port
      push_typed(OP_TICK, 8'h00, 1'b0, none);
      push_typed(OP_START, 8'hFF, 1'b1, none);          // start ignored, no collision
      push_reg(CSR_SPI_MODE, {1'b0, MODE_3});
      push_typed(OP_TICK, 8'h00, 1'b1, parked);         // sck parks high with cpol
      // fastest rate, mode 0, msb first: a full byte with a collision inside
      push_reg(CSR_RATE_SELECT, RATE_DIV2);
      push_reg(CSR_SPI_MODE, {1'b0, MODE_0});
      push_reg(CSR_LSB_FIRST, 3'b000);
      push_reg(CSR_ENABLE, 3'b001);
      push_tick(OP_START, 8'hA5, 1'b0);
      push_tick(OP_START, 8'h00, 1'b1);                 // start while busy
      push_run(15);
      // mode 3, lsb first, abandoned by disabling the port
      push_reg(CSR_SPI_MODE, {1'b0, MODE_3});
      push_reg(CSR_LSB_FIRST, 3'b001);
      push_tick(OP_START, 8'h01, 1'b1);
      push_run(3);
      push_reg(CSR_ENABLE, 3'b000);
      push_tick(OP_START, 8'hFF, 1'b0);                 // ignored while disabled
      push_reg(CSR_ENABLE, 3'b001);
      push_tick(OP_START, 8'h80, 1'b1);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (stim_table[i]) begin
         row = stim_table[i];
         case (row.kind)
            ROW_REG:  write_reg(row.reg_index, row.reg_value);
            ROW_TICK: offer(row.op, row.send, row.miso, row.typed, row.typed_rsp);
            default: begin
               repeat (row.count)
                  offer(OP_TICK, BYTE_W'($urandom), 1'($urandom), 1'b0, none);
            end
         endcase
      end

      // random phases, each under fresh register settings
      items_left = RANDOM_ITEMS;
      phase      = 0;
      burst_left = 0;
      while (items_left > 0) begin
         sel = $urandom_range(0, 19);
         if (phase == 0)
            rate = RATE_DIV128;
         else if (phase == 1)
            rate = RATE_DIV2;
         else if (sel < 12)
            rate = (sel % 3 == 0) ? RATE_DIV2 : (sel % 3 == 1) ? RATE_DIV4 : RATE_DIV8;
         else if (sel < 17)
            rate = sel[0] ? RATE_DIV16 : RATE_DIV32;
         else
            rate = (sel == 17) ? RATE_DIV64 : (sel == 18) ? RATE_DIV64_DBL : RATE_DIV128;
         mode = (phase < 4) ? MODE_W'(phase) : MODE_W'($urandom_range(0, 3));
         lsb  = 1'($urandom);
         en   = (phase == 5) ? 1'b0 : ($urandom_range(0, 9) != 0);

         // upper data bits carry noise that the registers must drop
         write_reg(CSR_RATE_SELECT, rate);
         write_reg(CSR_SPI_MODE, {1'($urandom), mode});
         write_reg(CSR_LSB_FIRST, {2'($urandom), lsb});
         write_reg(CSR_ENABLE, {2'($urandom), en});
         csr_write_enable <= 1'b0;
         @(posedge clock);
         if (phase == 2) hold_arm <= 1'b1;

         phase_items = (rate == RATE_DIV128 || rate == RATE_DIV64) ? 120
                                                                   : $urandom_range(30, 80);
         repeat (phase_items) begin
            // bursts of requests with random gaps between them
            if (burst_left == 0) begin
               gap = $urandom_range(0, 7);
               if (gap != 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            if (!spi_cfg.enable)
               op = 1'($urandom);
            else if (spi_st.active)
               op = ($urandom_range(0, 19) == 0) ? OP_START : OP_TICK;
            else
               op = ($urandom_range(0, 9) < 6) ? OP_START : OP_TICK;
            sel  = $urandom_range(0, 7);
            send = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : BYTE_W'($urandom);
            offer(op, send, 1'($urandom), 1'b0, none);
            items_left--;
         end
         phase++;
      end

      // drain
      req_valid        <= 1'b0;
      csr_write_enable <= 1'b0;
      waited = 0;
      while (expected_rsp.size() != 0 && waited < QUIET_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (expected_rsp.size() != 0)
         note_failure($sformatf("%0d responses never arrived", expected_rsp.size()));

      if (failures == 0) begin
         $display("spi_master_byte_exchange_top test passed");
      end else begin
         $display("spi_master_byte_exchange_top test failed");
      end
      $finish;
   end

endmodule
